FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the status byte parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define SCB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant violated");

// Check that a condition implies another in the same cycle.
`define SCB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

FILE: design/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Types, codes and helpers shared by the status byte command parser.
// ----------------------------------------------------------------------------
package scb_pkg;

    // Number of addressable pressure systems (1 to 8, set by the 3-bit index)
    localparam int NUM_SYSTEMS = 8;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 14;
    localparam int KIND_W  = 2;
    localparam int OUT_TDATA_W = 24;

    // Command codes as stored (low 3 bits of the 7-bit code)
    localparam logic [2:0] CODE_GOAL   = 3'd1;
    localparam logic [2:0] CODE_PWM    = 3'd6;
    localparam logic [2:0] CODE_ACTIVE = 3'd7;

    // Full 7-bit codes on the wire
    localparam logic [6:0] WIRE_GOAL   = 7'd1;
    localparam logic [6:0] WIRE_PWM    = 7'd6;
    localparam logic [6:0] WIRE_ACTIVE = 7'd7;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_GOAL  = 2'd3;
    localparam logic [1:0] LEN_SHORT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_GOAL   = 2'd0,
        KIND_PWM    = 2'd1,
        KIND_ACTIVE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
    } t_cmd;

    // Payload length selected by a command code
    function automatic logic [1:0] payload_length(input logic [DATA_W-1:0] code);
        logic [1:0] len;
        len = LEN_NONE;
        if (code == WIRE_GOAL) begin
            len = LEN_GOAL;
        end else if (code == WIRE_PWM || code == WIRE_ACTIVE) begin
            len = LEN_SHORT;
        end
        return len;
    endfunction

endpackage

FILE: design/status_byte_command_parser.sv
// ----------------------------------------------------------------------------
// status_byte_command_parser
// Frames a serial byte stream into decoded pressure-system commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one received byte per transfer on i_s_axis_tdata. Bytes
//   with bit 7 set start a command (goal pressure, pwm pressure, set active);
//   the following 7-bit bytes are its payload.
//   Master channel: one decoded command per transfer when the last payload
//   byte arrives and the system index is in range; tuser carries the kind,
//   tdata the index and value. Other bytes produce no transfer.
//   Path: the command of a completing byte passes the input register, then
//   the result register, and is offered on the master side from there; a
//   result still waiting can hold the byte in the input register.
//   Throughput: one byte per cycle while no completing byte waits for the
//   result register; the framer's decode between the registers is combinational.
//   Reset: framing returns to idle, both registers empty.
//   Stall: while a result waits, the input register still takes one byte;
//   bytes that produce no result keep flowing, a byte that completes a
//   command waits there until the result register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module status_byte_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave: [7:0] rx_byte
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // master tdata: [2:0] system_index, [16:3] command_value, [23:17] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    // master tuser: [1:0] command_kind
    output logic [1:0]  o_m_axis_tuser
);
    import scb_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    logic   emit;
    logic   out_free;
    logic   advance;
    logic   load;
    t_cmd   dec_cmd;
    t_cmd   out_cmd;

    // Move the held byte on when its result has room or it has none
    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign advance         = r_in_valid && (out_free || !emit);
    assign load            = advance && emit;
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    scb_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_emit    (emit),
        .o_cmd     (dec_cmd)
    );

    scb_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_cmd   (dec_cmd),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_cmd   (out_cmd)
    );

    // Pack result fields
    assign o_m_axis_tdata = {{(OUT_TDATA_W-INDEX_W-VALUE_W){1'b0}},
                             out_cmd.value, out_cmd.index};
    assign o_m_axis_tuser = out_cmd.kind;

    `SCB_ASSERT_IMPLY(a_load_needs_room, i_clk, i_rst_n, load,
        r_in_valid && (!o_m_axis_tvalid || i_m_axis_tready))

endmodule

FILE: design/scb_framer.sv
// ----------------------------------------------------------------------------
// scb_framer
// Framing state and command decode for one registered byte per cycle while i_advance is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scb_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,  // consume i_byte this cycle
    input  logic [scb_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_emit,     // i_byte completes a command with its index in range
    output scb_pkg::t_cmd               o_cmd
);
    import scb_pkg::*;

    logic                r_receiving;
    logic [2:0]          r_command_code;
    logic [1:0]          r_bytes_left;
    logic [1:0]          r_byte_index;
    logic [DATA_W-1:0]   r_payload0;
    logic [DATA_W-1:0]   r_payload1;

    logic [DATA_W-1:0]   data;
    logic [1:0]          len;
    logic                is_command;
    logic                last_byte;
    logic                index_ok;

    assign data       = i_byte[DATA_W-1:0];
    assign is_command = i_byte[BYTE_W-1];
    assign len        = payload_length(data);
    assign last_byte  = !is_command && r_receiving && (r_bytes_left == 2'd1);
    assign index_ok   = {1'b0, r_payload0} < (DATA_W+1)'(NUM_SYSTEMS);

    // Decode the command that the last payload byte completes
    always_comb begin
        o_cmd.index = r_payload0[INDEX_W-1:0];
        o_cmd.kind  = KIND_GOAL;
        o_cmd.value = '0;
        o_emit      = 1'b0;
        case (r_command_code)
            CODE_GOAL: begin
                o_cmd.kind  = KIND_GOAL;
                o_cmd.value = {r_payload1, data};
                o_emit      = last_byte && index_ok;
            end
            CODE_PWM: begin
                o_cmd.kind  = KIND_PWM;
                o_cmd.value = VALUE_W'(data);
                o_emit      = last_byte && index_ok;
            end
            CODE_ACTIVE: begin
                o_cmd.kind  = KIND_ACTIVE;
                o_cmd.value = VALUE_W'(data != '0);
                o_emit      = last_byte && index_ok;
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    // Advance framing state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving    <= 1'b0;
            r_command_code <= '0;
            r_bytes_left   <= '0;
            r_byte_index   <= '0;
        end else if (i_advance) begin
            if (is_command) begin
                r_command_code <= data[2:0];
                r_byte_index   <= '0;
                r_bytes_left   <= len;
                r_receiving    <= (len != LEN_NONE);
            end else if (r_receiving) begin
                r_byte_index <= r_byte_index + 2'd1;
                r_bytes_left <= r_bytes_left - 2'd1;
                if (r_bytes_left == 2'd1) begin
                    r_receiving <= 1'b0;
                end
            end
        end
    end

    // Store the first two payload bytes
    always_ff @(posedge i_clk) begin
        if (i_advance && !is_command && r_receiving) begin
            if (r_byte_index == 2'd0) begin
                r_payload0 <= data;
            end
            if (r_byte_index == 2'd1) begin
                r_payload1 <= data;
            end
        end
    end

    `SCB_ASSERT_ALWAYS(a_recv_matches_count, i_clk, i_rst_n,
        r_receiving == (r_bytes_left != 2'd0))
    `SCB_ASSERT_IMPLY(a_recv_known_code, i_clk, i_rst_n, r_receiving,
        r_command_code == CODE_GOAL || r_command_code == CODE_PWM || r_command_code == CODE_ACTIVE)

endmodule

FILE: design/scb_result_reg.sv
// ----------------------------------------------------------------------------
// scb_result_reg
// Result register that holds a decoded command until the receiver takes it.
// ----------------------------------------------------------------------------
module scb_result_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  scb_pkg::t_cmd   i_cmd,
    input  logic            i_ready,
    output logic            o_valid,
    output scb_pkg::t_cmd   o_cmd
);
    import scb_pkg::*;

    logic   r_valid;
    t_cmd   r_cmd;

    // Valid flag: set on load, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the status byte command parser. A driver streams
// command and payload bytes from a queue into the slave side. A monitor
// decodes every accepted byte with its own copy of the framing state and
// compares each decoded command on the master side with the oldest one
// predicted. Both sides idle at random in phases. One long receiver hold-off
// backs the parser up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scb_pkg::*;

    localparam int RANDOM_BYTES = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // DUT connections; the driven inputs are known from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    // Byte stream still to send and commands still to arrive
    logic [7:0]  tx_bytes [$];
    t_cmd        pending_cmds [$];

    // Framing state of the decoder copy
    logic        framing       = 1'b0;
    logic [2:0]  frame_code    = 3'd0;
    logic [1:0]  frame_left    = 2'd0;
    logic [1:0]  frame_pos     = 2'd0;
    logic [6:0]  frame_payload [2] = '{7'd0, 7'd0};

    // Bookkeeping
    logic        s_taken       = 1'b0;
    int          total_bytes   = 0;
    int          bytes_taken   = 0;
    int          cmds_checked  = 0;
    int          goal_count    = 0;
    int          pwm_count     = 0;
    int          active_count  = 0;
    int          suppressed    = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;

    status_byte_command_parser i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Count a failure, print only the first few
    task automatic report_failure(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // Idle percentage per side: sender light / receiver heavy, then swapped,
    // then no idling at all
    function automatic int idle_pct(input bit receiver);
        if (bytes_taken < total_bytes / 3) begin
            return receiver ? 70 : 14;
        end else if (bytes_taken < (2 * total_bytes) / 3) begin
            return receiver ? 14 : 70;
        end
        return 0;
    endfunction

    // Advance the framing state by one byte; flag a decoded command
    task automatic decode_rx_byte(input logic [7:0] rx, output bit produced, output t_cmd cmd);
        logic [6:0] code;
        logic [1:0] len;
        produced = 1'b0;
        cmd      = '0;
        if (rx[7]) begin
            // Command byte: restart framing, unknown codes go idle
            code = rx[6:0];
            if (code == WIRE_GOAL) begin
                len = LEN_GOAL;
            end else if (code == WIRE_PWM || code == WIRE_ACTIVE) begin
                len = LEN_SHORT;
            end else begin
                len = LEN_NONE;
            end
            frame_code = code[2:0];
            frame_pos  = 2'd0;
            frame_left = len;
            framing    = (len != LEN_NONE);
        end else if (framing) begin
            // Payload byte: keep the first two, finish on the last
            if (frame_pos < 2'd2) begin
                frame_payload[frame_pos[0]] = rx[6:0];
            end
            frame_pos  = frame_pos + 2'd1;
            frame_left = frame_left - 2'd1;
            if (frame_left == 2'd0) begin
                framing = 1'b0;
                if (frame_payload[0] >= NUM_SYSTEMS) begin
                    suppressed++;
                end else begin
                    produced  = 1'b1;
                    cmd.index = frame_payload[0][INDEX_W-1:0];
                    case (frame_code)
                        CODE_GOAL: begin
                            cmd.kind  = KIND_GOAL;
                            cmd.value = {frame_payload[1], rx[6:0]};
                        end
                        CODE_PWM: begin
                            cmd.kind  = KIND_PWM;
                            cmd.value = {7'd0, rx[6:0]};
                        end
                        CODE_ACTIVE: begin
                            cmd.kind  = KIND_ACTIVE;
                            cmd.value = (rx != 8'd0) ? 14'd1 : 14'd0;
                        end
                        default: begin
                            produced = 1'b0;
                        end
                    endcase
                end
            end
        end
    endtask

    // Driver: hold the byte until its transfer, then offer the next one
    always @(negedge clk) begin : drive_bytes
        int roll;
        roll = $urandom_range(99);
        if (rst_n && (!s_tvalid || s_taken)) begin
            if (tx_bytes.size() != 0 && roll >= idle_pct(1'b0)) begin
                s_tdata  <= tx_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off late in the run
    always @(negedge clk) begin : drive_ready
        int roll;
        roll = $urandom_range(99);
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= (3 * total_bytes) / 4) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= (roll >= idle_pct(1'b1));
        end
    end

    // Monitor: check master transfers, predict on slave transfers
    always @(posedge clk) begin : watch_ports
        t_cmd want;
        t_cmd got;
        bit   produced;
        s_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.kind  = t_kind'(m_tuser);
                got.index = m_tdata[2:0];
                got.value = m_tdata[16:3];
                if (pending_cmds.size() == 0) begin
                    report_failure($sformatf("unexpected command kind=%0d index=%0d value=%0d",
                                             m_tuser, got.index, got.value));
                end else begin
                    want = pending_cmds.pop_front();
                    cmds_checked++;
                    case (want.kind)
                        KIND_GOAL:   goal_count++;
                        KIND_PWM:    pwm_count++;
                        default:     active_count++;
                    endcase
                    if (m_tuser != want.kind || got.index != want.index ||
                        got.value != want.value || m_tdata[23:17] != 7'd0) begin
                        report_failure({
                            $sformatf("command %0d: exp kind=%0d index=%0d value=%0d",
                                      cmds_checked, want.kind, want.index, want.value),
                            $sformatf(", got kind=%0d index=%0d value=%0d pad=%0h",
                                      m_tuser, got.index, got.value, m_tdata[23:17])});
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_taken <= bytes_taken + 1;
                decode_rx_byte(s_tdata, produced, want);
                if (produced) begin
                    pending_cmds.push_back(want);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, pending_cmds.size());
            $display("status_byte_command_parser regression: fail");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : run_test
        int         roll;
        int         pick;
        int         plen;
        int         keep;
        int         drain;
        logic [6:0] op;
        logic [6:0] idx;
        logic [6:0] data;

        // Directed: extremes, each command, idle drops, restarts, range
        tx_bytes = '{8'h81, 8'h00, 8'h7F, 8'h7F,   // goal, index 0, max value
                     8'h86, 8'h07, 8'h00,          // pwm, index 7, zero
                     8'h87, 8'h03, 8'h40,          // active on
                     8'h87, 8'h01, 8'h00,          // active off
                     8'h81, 8'h02, 8'h86, 8'h05, 8'h01,  // restart mid-payload
                     8'hFF, 8'h12,                 // unknown code, then dropped
                     8'h80,                        // payload-free code
                     8'h86, 8'h7F, 8'h03};         // index out of range

        // Random: mostly frames, some truncated, some noise
        while (tx_bytes.size() < RANDOM_BYTES + 24) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                tx_bytes.push_back(8'($urandom_range(255)));
            end else begin
                pick = $urandom_range(2);
                op   = (pick == 0) ? WIRE_GOAL : (pick == 1) ? WIRE_PWM : WIRE_ACTIVE;
                plen = (op == WIRE_GOAL) ? 3 : 2;
                if ($urandom_range(99) < 10) begin
                    idx = 7'($urandom_range(127, NUM_SYSTEMS));
                end else begin
                    idx = 7'($urandom_range(NUM_SYSTEMS - 1));
                end
                keep = (roll < 20) ? $urandom_range(plen - 1) : plen;
                tx_bytes.push_back({1'b1, op});
                if (keep > 0) begin
                    tx_bytes.push_back({1'b0, idx});
                end
                for (int k = 1; k < keep; k++) begin
                    data = 7'($urandom_range(127));
                    // bias set active toward the zero payload
                    if (op == WIRE_ACTIVE && $urandom_range(1) == 0) begin
                        data = 7'd0;
                    end
                    tx_bytes.push_back({1'b0, data});
                end
            end
        end
        total_bytes = tx_bytes.size();

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every byte has been transferred
        while (tx_bytes.size() != 0 || s_tvalid) begin
            @(negedge clk);
        end

        // Drain outstanding commands
        drain = 0;
        while (pending_cmds.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge clk);
            drain++;
        end
        if (pending_cmds.size() != 0) begin
            report_failure($sformatf("%0d commands never arrived", pending_cmds.size()));
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("sent %0d bytes; checked %0d commands (goal %0d, pwm %0d, active %0d)",
                 total_bytes, cmds_checked, goal_count, pwm_count, active_count);
        $display("%0d commands suppressed by index range, %0d failures, one %0d-cycle hold-off",
                 suppressed, error_count, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("status_byte_command_parser regression: pass");
        end else begin
            $display("status_byte_command_parser regression: fail");
        end
        $finish;
    end

endmodule
